FILE: rtl/core/polyjw_pkg.sv
// ----------------------------------------------------------------------------
// polyjw_pkg: shared types and constants for the j-omega polynomial evaluator
// Widths, formats, microcode word layout and the microcode program.
// ----------------------------------------------------------------------------
`default_nettype none

package polyjw_pkg;

  // Formats: inputs Qx.FRAC_BITS in IN_W bits, wide values in WIDE_W bits
  localparam int FRAC_BITS     = 16;
  localparam int HIGHEST_ORDER = 15;
  localparam int COEF_DEPTH    = HIGHEST_ORDER + 1;
  localparam int IDX_W         = 4;
  localparam int IN_W          = 32;
  localparam int WIDE_W        = 48;
  localparam int SUM_W         = WIDE_W + 2;
  localparam int PROD_W        = 2 * IN_W;
  localparam int HI_SHIFT      = IN_W - FRAC_BITS;

  localparam logic [WIDE_W-1:0] MAG_POS_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic [WIDE_W-1:0] MAG_NEG_MAX = {1'b1, {(WIDE_W-1){1'b0}}};
  localparam logic [WIDE_W-1:0] POW_ONE     = WIDE_W'(1) << FRAC_BITS;
  localparam logic [WIDE_W-1:0] HI_LIMIT    = MAG_NEG_MAX >> HI_SHIFT;

  // Request modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // Configuration space
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ORDER_W    = 4;
  localparam logic [CFG_ADDR_W-1:0] REG_ORDER = CFG_ADDR_W'(0);

  // Microcode
  typedef logic [2:0] upc_t;

  localparam upc_t UPC_TLO  = 3'd0;  // term product, low half
  localparam upc_t UPC_THI  = 3'd1;  // term product, high half
  localparam upc_t UPC_TFIN = 3'd2;  // term round/saturate, power product low half
  localparam upc_t UPC_PACC = 3'd3;  // accumulate, power product high half
  localparam upc_t UPC_PFIN = 3'd4;  // power round/saturate, next index
  localparam upc_t UPC_DONE = 3'd5;  // hand result to output register

  typedef struct packed {
    logic mul_en;   // run the shared multiplier
    logic mul_hi;   // operand A is upper magnitude bits, result to hi half
    logic mul_w;    // operand B is w (else coefficient)
    logic fin_en;   // round and saturate the product halves
    logic fin_pow;  // finished product goes to power (else term)
    logic acc_en;   // add/subtract term into real or imag
    logic idx_inc;  // advance term index
    logic br_last;  // branch to target when on last term
    logic jump;     // unconditional branch to target
    logic done;     // result step
    upc_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t uc;
    uc = '0;
    case (pc)
      UPC_TLO: begin
        uc.mul_en = 1'b1;
      end
      UPC_THI: begin
        uc.mul_en = 1'b1;
        uc.mul_hi = 1'b1;
      end
      UPC_TFIN: begin
        uc.fin_en = 1'b1;
        uc.mul_en = 1'b1;
        uc.mul_w  = 1'b1;
      end
      UPC_PACC: begin
        uc.acc_en  = 1'b1;
        uc.mul_en  = 1'b1;
        uc.mul_hi  = 1'b1;
        uc.mul_w   = 1'b1;
        uc.br_last = 1'b1;
        uc.target  = UPC_DONE;
      end
      UPC_PFIN: begin
        uc.fin_en  = 1'b1;
        uc.fin_pow = 1'b1;
        uc.idx_inc = 1'b1;
        uc.jump    = 1'b1;
        uc.target  = UPC_TLO;
      end
      UPC_DONE: begin
        uc.done = 1'b1;
      end
      default: begin
        uc.done = 1'b1;
      end
    endcase
    return uc;
  endfunction

  // Magnitude of a signed input word; the most negative value maps to 2^(IN_W-1)
  function automatic logic [IN_W-1:0] mag_in(input logic [IN_W-1:0] v);
    return v[IN_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/polyjw_if.sv
// ----------------------------------------------------------------------------
// polyjw_in_if / polyjw_out_if: request and result channels
// Valid/ready channels carrying the evaluator's request and result payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface polyjw_in_if import polyjw_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [IDX_W-1:0]        coef_index;
  logic signed [IN_W-1:0]  coef_value;
  logic signed [IN_W-1:0]  w;

  modport source (output valid, mode, coef_index, coef_value, w, input ready);
  modport sink   (input valid, mode, coef_index, coef_value, w, output ready);
endinterface

interface polyjw_out_if import polyjw_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [WIDE_W-1:0] real_part;
  logic signed [WIDE_W-1:0] imag_part;
  logic                     overflow;

  modport source (output valid, real_part, imag_part, overflow, input ready);
  modport sink   (input valid, real_part, imag_part, overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/polynomial_eval_at_jw_core.sv
// ----------------------------------------------------------------------------
// polynomial_eval_at_jw_core: polynomial evaluation at s = jw
// Coefficient store plus a microcoded multiply/round/accumulate datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests. mode = load writes coef_value (Q16.16) into slot
//   coef_index; it gives no result and leaves in_ch.ready high, so a new request
//   may follow in the next cycle. mode = evaluate starts a walk over
//   coefficients 0..order at frequency w (Q16.16) and yields one result on
//   out_ch: real_part, imag_part (Q32.16, saturated) and overflow.
//   Evaluate: in_ch.ready stays low from the request until the result register
//   loads, so no new request is taken while an evaluation runs. The pace is
//   set by the single 32x32 multiplier: each term takes two half products for
//   the term and two for the next power, plus a round/saturate step for each
//   (the last term skips the power round/saturate step).
//   order is written through the APB port (address 0) while idle.
//   Reset clears order, all coefficients, the busy state and the result valid.
//   A stalled out_ch holds its result; the next evaluation runs meanwhile
//   and waits in its final step until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_eval_at_jw_core import polyjw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  polyjw_in_if.sink             in_ch,
  polyjw_out_if.source          out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // ---------------- configuration ----------------
  logic [ORDER_W-1:0]    order_r;
  logic                  cfg_wr;
  logic [CFG_ADDR_W-1:0] cfg_reg;

  assign pready  = 1'b1;
  assign cfg_reg = paddr >> 2;
  assign cfg_wr  = psel & penable & pwrite & (cfg_reg == REG_ORDER);
  assign prdata  = (cfg_reg == REG_ORDER) ? CFG_DATA_W'(order_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
    end else if (cfg_wr) begin
      order_r <= pwdata[ORDER_W-1:0];
    end
  end

  // ---------------- sequencer state ----------------
  logic   busy_r;
  upc_t   pc_r;
  ucode_t uc;
  logic   in_acc;
  logic   eval_start;
  logic   load_wr;
  logic   slot_free;
  logic   done_fire;
  logic   last_term;

  assign in_ch.ready = ~busy_r;
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign eval_start  = in_acc & (in_ch.mode == MODE_EVAL);
  assign load_wr     = in_acc & (in_ch.mode == MODE_LOAD) &
                       (int'(in_ch.coef_index) <= HIGHEST_ORDER);

  // control word is only acted on while busy
  assign uc = busy_r ? ucode_rom(pc_r) : '0;

  // ---------------- coefficient store (sign/magnitude) ----------------
  logic [IN_W-1:0]       coef_mag_r [COEF_DEPTH];
  logic [COEF_DEPTH-1:0] coef_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < COEF_DEPTH; k++) begin
        coef_mag_r[k] <= '0;
      end
      coef_neg_r <= '0;
    end else if (load_wr) begin
      coef_mag_r[in_ch.coef_index] <= mag_in(in_ch.coef_value);
      coef_neg_r[in_ch.coef_index] <= in_ch.coef_value[IN_W-1];
    end
  end

  // ---------------- datapath registers ----------------
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  top_r;
  logic [IN_W-1:0]   w_mag_r;
  logic              w_neg_r;
  logic [WIDE_W-1:0] pow_mag_r;
  logic              pow_neg_r;
  logic [PROD_W-1:0] lo_r;
  logic [WIDE_W-1:0] hi_r;
  logic              prod_neg_r;
  logic [WIDE_W-1:0] term_mag_r;
  logic              term_neg_r;
  logic [WIDE_W-1:0] re_r;
  logic [WIDE_W-1:0] im_r;
  logic              ovf_r;

  assign last_term = (idx_r == top_r);

  // shared multiplier: unsigned magnitudes, one half of the wide operand per step
  logic [IN_W-1:0]   op_a;
  logic [IN_W-1:0]   op_b;
  logic              op_neg;
  logic [PROD_W-1:0] prod;

  assign op_a   = uc.mul_hi ? IN_W'(pow_mag_r[WIDE_W-1:IN_W]) : pow_mag_r[IN_W-1:0];
  assign op_b   = uc.mul_w ? w_mag_r : coef_mag_r[idx_r];
  assign op_neg = pow_neg_r ^ (uc.mul_w ? w_neg_r : coef_neg_r[idx_r]);
  assign prod   = op_a * op_b;

  // round (truncate toward zero) and saturate the product halves
  logic              hi_ovf;
  logic [SUM_W-1:0]  q;
  logic              fin_ovf;
  logic [WIDE_W-1:0] fin_mag;

  assign hi_ovf = hi_r > HI_LIMIT;
  assign q      = (SUM_W'(hi_r) << HI_SHIFT) + SUM_W'(lo_r >> FRAC_BITS);

  always_comb begin
    fin_ovf = 1'b0;
    fin_mag = q[WIDE_W-1:0];
    if (hi_ovf) begin
      fin_ovf = 1'b1;
      fin_mag = prod_neg_r ? MAG_NEG_MAX : MAG_POS_MAX;
    end else if (prod_neg_r) begin
      if (q > SUM_W'(MAG_NEG_MAX)) begin
        fin_ovf = 1'b1;
        fin_mag = MAG_NEG_MAX;
      end
    end else if (q > SUM_W'(MAG_POS_MAX)) begin
      fin_ovf = 1'b1;
      fin_mag = MAG_POS_MAX;
    end
  end

  // accumulate: idx bit 0 picks imag, bit 1 flips the sign of the term
  logic [WIDE_W-1:0]       acc_old;
  logic                    acc_sub;
  logic signed [SUM_W-1:0] acc_ext;
  logic signed [SUM_W-1:0] mag_ext;
  logic signed [SUM_W-1:0] sum;
  logic                    acc_ovf;
  logic [WIDE_W-1:0]       acc_res;

  assign acc_old = idx_r[0] ? im_r : re_r;
  assign acc_sub = term_neg_r ^ idx_r[1];
  assign acc_ext = SUM_W'($signed(acc_old));
  assign mag_ext = $signed({{(SUM_W-WIDE_W){1'b0}}, term_mag_r});
  assign sum     = acc_sub ? (acc_ext - mag_ext) : (acc_ext + mag_ext);
  assign acc_ovf = ~((&sum[SUM_W-1:WIDE_W-1]) | ~(|sum[SUM_W-1:WIDE_W-1]));
  assign acc_res = acc_ovf ? (sum[SUM_W-1] ? MAG_NEG_MAX : MAG_POS_MAX)
                           : sum[WIDE_W-1:0];

  // ---------------- output register ----------------
  logic              out_valid_r;
  logic [WIDE_W-1:0] out_re_r;
  logic [WIDE_W-1:0] out_im_r;
  logic              out_ovf_r;

  assign slot_free = ~out_valid_r | out_ch.ready;
  assign done_fire = uc.done & slot_free;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.real_part = out_re_r;
  assign out_ch.imag_part = out_im_r;
  assign out_ch.overflow  = out_ovf_r;

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= UPC_TLO;
      out_valid_r <= 1'b0;
    end else begin
      if (eval_start) begin
        busy_r <= 1'b1;
        pc_r   <= UPC_TLO;
      end else if (busy_r) begin
        if (uc.done) begin
          if (slot_free) begin
            busy_r <= 1'b0;
          end
        end else if (uc.jump || (uc.br_last && last_term)) begin
          pc_r <= uc.target;
        end else begin
          pc_r <= pc_r + 1'b1;
        end
      end

      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (eval_start) begin
      w_mag_r   <= mag_in(in_ch.w);
      w_neg_r   <= in_ch.w[IN_W-1];
      pow_mag_r <= POW_ONE;
      pow_neg_r <= 1'b0;
      idx_r     <= '0;
      top_r     <= (int'(order_r) > HIGHEST_ORDER) ? IDX_W'(HIGHEST_ORDER) : order_r;
      re_r      <= '0;
      im_r      <= '0;
      ovf_r     <= 1'b0;
    end else begin
      if (uc.mul_en) begin
        if (uc.mul_hi) begin
          hi_r <= prod[WIDE_W-1:0];
        end else begin
          lo_r       <= prod;
          prod_neg_r <= op_neg;
        end
      end
      if (uc.fin_en) begin
        if (uc.fin_pow) begin
          pow_mag_r <= fin_mag;
          pow_neg_r <= prod_neg_r;
        end else begin
          term_mag_r <= fin_mag;
          term_neg_r <= prod_neg_r;
        end
      end
      if (uc.acc_en) begin
        if (idx_r[0]) begin
          im_r <= acc_res;
        end else begin
          re_r <= acc_res;
        end
      end
      if (uc.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      ovf_r <= ovf_r | (uc.fin_en & fin_ovf) | (uc.acc_en & acc_ovf);
    end

    if (done_fire) begin
      out_re_r  <= re_r;
      out_im_r  <= im_r;
      out_ovf_r <= ovf_r;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/polyjw_checker.sv
// ----------------------------------------------------------------------------
// polyjw_checker: port-level checks for the j-omega polynomial evaluator
// Watches the request and result channels; bound to polynomial_eval_at_jw_core.
// ----------------------------------------------------------------------------
`default_nettype none

module polyjw_checker import polyjw_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_mode,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [WIDE_W-1:0] out_real_part,
  input wire logic [WIDE_W-1:0] out_imag_part,
  input wire logic              out_overflow
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_real_part) &&
    $stable(out_imag_part) && $stable(out_overflow))
    else $error("result changed or dropped while stalled");

  // an evaluate request blocks the request channel on the next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_EVAL) |=> !in_ready)
    else $error("request taken while evaluation in progress");

  // a load request never blocks the channel
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_LOAD) |=> in_ready)
    else $error("load request stalled the request channel");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind polynomial_eval_at_jw_core polyjw_checker u_polyjw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_mode       (in_ch.mode),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_real_part (out_ch.real_part),
  .out_imag_part (out_ch.imag_part),
  .out_overflow  (out_ch.overflow)
);

`default_nettype wire
